### sv/rbd_pkg.sv
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types and constants of the run-length byte decoder: the command that
// passes from the header parser to the beat generator, and the limits.
// ----------------------------------------------------------------------------
package rbd_pkg;

   localparam int OUT_LANES   = 4;   // default lanes per output beat
   localparam int MAX_LANES   = 4;   // lanes physically present on the port
   localparam int MAX_BEATS   = 32;  // beats one run may emit
   localparam int QUEUE_DEPTH = 2;   // commands between front and back

   localparam logic [7:0] RUN_FLAG   = 8'h80;
   localparam logic [7:0] COUNT_MASK = 8'h7F;

   // What the back end has to do for one input item
   typedef enum logic [1:0] {
      CMD_RUN  = 2'd0,   // repeat data count times
      CMD_LIT  = 2'd1,   // one literal byte
      CMD_MARK = 2'd2    // no data, closing beat only
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
      logic [6:0]   count;
      logic         last;    // item was the final byte of the stream
      logic         trunc;   // stream ends inside a packet
   } cmd_type;

endpackage

### sv/rbd_front.sv
// ----------------------------------------------------------------------------
// rbd_front
// Header parser: accepts compressed bytes, tracks packet phase and the count
// still owed, and issues one command for every item that yields output.
// ----------------------------------------------------------------------------
module rbd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_in_byte,
   input  logic             req_last_byte,
   input  logic             queue_full,
   output logic             push,
   output rbd_pkg::cmd_type push_cmd
);

   typedef enum logic [2:0] {
      PH_HEADER = 3'b001,
      PH_RUNVAL = 3'b010,
      PH_LIT    = 3'b100
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [6:0] pending_ff, pending_in;
   logic       accept;
   logic [6:0] hdr_count;
   logic       gen;

   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;
   assign hdr_count = 7'(req_in_byte & rbd_pkg::COUNT_MASK);

   always_comb begin
      phase_in       = phase_ff;
      pending_in     = pending_ff;
      gen            = 1'b0;
      push_cmd.kind  = rbd_pkg::CMD_MARK;
      push_cmd.data  = req_in_byte;
      push_cmd.count = pending_ff;
      push_cmd.last  = req_last_byte;
      push_cmd.trunc = 1'b0;
      unique case (phase_ff)
         PH_RUNVAL: begin
            // zero run still swallows its value byte
            gen            = (pending_ff != 7'd0) || req_last_byte;
            push_cmd.kind  = (pending_ff != 7'd0) ? rbd_pkg::CMD_RUN : rbd_pkg::CMD_MARK;
            phase_in       = PH_HEADER;
            pending_in     = 7'd0;
         end
         PH_LIT: begin
            gen            = 1'b1;
            push_cmd.kind  = rbd_pkg::CMD_LIT;
            pending_in     = pending_ff - 7'd1;
            phase_in       = (pending_ff == 7'd1) ? PH_HEADER : PH_LIT;
            push_cmd.trunc = (pending_ff != 7'd1);
         end
         default: begin
            gen            = req_last_byte;
            push_cmd.trunc = ((req_in_byte & rbd_pkg::RUN_FLAG) != 8'd0)
                             || (hdr_count != 7'd0);
            if ((req_in_byte & rbd_pkg::RUN_FLAG) != 8'd0) begin
               phase_in   = PH_RUNVAL;
               pending_in = hdr_count;
            end else if (hdr_count != 7'd0) begin
               phase_in   = PH_LIT;
               pending_in = hdr_count;
            end else begin
               phase_in   = PH_HEADER;
            end
         end
      endcase
      if (req_last_byte) begin
         phase_in   = PH_HEADER;
         pending_in = 7'd0;
      end
   end

   assign push = accept && gen;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_HEADER;
         pending_ff <= 7'd0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         pending_ff <= pending_in;
      end
   end

endmodule

### sv/rbd_queue.sv
// ----------------------------------------------------------------------------
// rbd_queue
// Short command queue between parser and beat generator.
// ----------------------------------------------------------------------------
module rbd_queue #(
   parameter int DEPTH = rbd_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rbd_pkg::cmd_type push_cmd,
   input  logic             pop,
   output rbd_pkg::cmd_type head_cmd,
   output logic             empty,
   output logic             full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rbd_pkg::cmd_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign empty    = (count_ff == CNT_W'(0));
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign head_cmd = slot_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : p + PTR_W'(1);
   endfunction

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= next_ptr(wr_ptr_ff);
         if (pop)  rd_ptr_ff <= next_ptr(rd_ptr_ff);
         if (push && !pop)      count_ff <= count_ff + CNT_W'(1);
         else if (pop && !push) count_ff <= count_ff - CNT_W'(1);
      end
   end

endmodule

### sv/rbd_back.sv
// ----------------------------------------------------------------------------
// rbd_back
// Beat generator: carries out one command at a time, splitting runs into
// beats of up to the configured lane count, and keeps the running length.
// ----------------------------------------------------------------------------
module rbd_back #(
   parameter int OUT_LANES = rbd_pkg::OUT_LANES
) (
   input  logic             clock,
   input  logic             reset,
   input  rbd_pkg::cmd_type head_cmd,
   input  logic             queue_empty,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [31:0]      rsp_out_lanes,
   output logic [2:0]       rsp_lane_count,
   output logic             rsp_last_of_input,
   output logic             rsp_stream_done,
   output logic [31:0]      rsp_total_length,
   output logic             rsp_truncated
);

   localparam int LANES_PER = (OUT_LANES < 1) ? 1 :
                              (OUT_LANES > rbd_pkg::MAX_LANES) ? rbd_pkg::MAX_LANES
                                                               : OUT_LANES;
   localparam int BEAT_W    = $clog2(rbd_pkg::MAX_BEATS);

   rbd_pkg::cmd_type  act_ff;
   logic              act_valid_ff;
   logic [6:0]        left_ff;
   logic [BEAT_W-1:0] beat_ff;
   logic [31:0]       total_ff;

   logic [31:0] lanes_ff;
   logic [2:0]  cnt_ff;
   logic        last_in_ff, done_ff, trunc_ff, valid_ff;
   logic [31:0] length_ff;

   logic        out_load, final_beat, act_free;
   logic [2:0]  take;
   logic [6:0]  add;
   logic [31:0] lanes;
   logic [32:0] sum;
   logic [31:0] new_total;

   always_comb begin
      take = 3'd0;
      add  = 7'd0;
      final_beat = 1'b1;
      lanes = 32'd0;
      case (act_ff.kind)
         rbd_pkg::CMD_RUN: begin
            take = (left_ff < 7'(LANES_PER)) ? left_ff[2:0] : 3'(LANES_PER);
            // run capped in beats; the leftover is still counted
            final_beat = (left_ff == 7'(take)) ||
                         (beat_ff == BEAT_W'(rbd_pkg::MAX_BEATS - 1));
            add = final_beat ? left_ff : 7'(take);
            for (int i = 0; i < rbd_pkg::MAX_LANES; i++) begin
               lanes[8*i +: 8] = (3'(i) < take) ? act_ff.data : 8'd0;
            end
         end
         rbd_pkg::CMD_LIT: begin
            take  = 3'd1;
            add   = 7'd1;
            lanes = {24'd0, act_ff.data};
         end
         default: begin
         end
      endcase
   end

   assign sum       = {1'b0, total_ff} + 33'(add);
   assign new_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

   assign out_load = act_valid_ff && (!valid_ff || !rsp_stall);
   assign act_free = !act_valid_ff || (out_load && final_beat);
   assign pop      = !queue_empty && act_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         act_valid_ff <= 1'b0;
         valid_ff     <= 1'b0;
         total_ff     <= 32'd0;
      end else begin
         if (pop) begin
            act_valid_ff <= 1'b1;
         end else if (act_free) begin
            act_valid_ff <= 1'b0;
         end
         if (out_load) begin
            valid_ff <= 1'b1;
            total_ff <= (final_beat && act_ff.last) ? 32'd0 : new_total;
         end else if (!rsp_stall) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         act_ff  <= head_cmd;
         left_ff <= head_cmd.count;
         beat_ff <= '0;
      end else if (out_load) begin
         left_ff <= left_ff - 7'(take);
         beat_ff <= beat_ff + BEAT_W'(1);
      end
      if (out_load) begin
         lanes_ff   <= lanes;
         cnt_ff     <= take;
         last_in_ff <= final_beat;
         done_ff    <= final_beat && act_ff.last;
         trunc_ff   <= final_beat && act_ff.last && act_ff.trunc;
         length_ff  <= new_total;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_out_lanes     = lanes_ff;
   assign rsp_lane_count    = cnt_ff;
   assign rsp_last_of_input = last_in_ff;
   assign rsp_stream_done   = done_ff;
   assign rsp_total_length  = length_ff;
   assign rsp_truncated     = trunc_ff;

endmodule

### sv/rle_byte_decoder.sv
// ----------------------------------------------------------------------------
// rle_byte_decoder
// An item's first beat raises rsp_valid once the item has passed the queue
// write, then the command load, then the output load.
// Throughput: one compressed byte per cycle for headers and literals while
// the queue has room; a run of n bytes gives ceil(n/lanes) beats, at most 32.
// Reset: synchronous, clears parser phase, queue, running length, valids.
// ----------------------------------------------------------------------------
module rle_byte_decoder #(
   parameter int OUT_LANES   = rbd_pkg::OUT_LANES,    // lanes per beat, clamped to 1..4
   parameter int QUEUE_DEPTH = rbd_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_lanes,
   output logic [2:0]  rsp_lane_count,
   output logic        rsp_last_of_input,
   output logic        rsp_stream_done,
   output logic [31:0] rsp_total_length,
   output logic        rsp_truncated
);

   // Front: parses headers, one item a cycle, stalls only on a full queue.
   // Header bytes that close nothing leave no command behind.
   // Back: turns each command into beats; a run holds it over all its beats
   // while the front keeps taking bytes into the queue until it is full.

   rbd_pkg::cmd_type push_cmd, head_cmd;
   logic             push, pop, queue_full, queue_empty;

   rbd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .req_last_byte (req_last_byte),
      .queue_full    (queue_full),
      .push          (push),
      .push_cmd      (push_cmd)
   );

   rbd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   // running length lives in the back end, cleared after each closing beat
   rbd_back #(
      .OUT_LANES (OUT_LANES)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .head_cmd          (head_cmd),
      .queue_empty       (queue_empty),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_lanes     (rsp_out_lanes),
      .rsp_lane_count    (rsp_lane_count),
      .rsp_last_of_input (rsp_last_of_input),
      .rsp_stream_done   (rsp_stream_done),
      .rsp_total_length  (rsp_total_length),
      .rsp_truncated     (rsp_truncated)
   );

endmodule

### sv/rbd_checker.sv
// ----------------------------------------------------------------------------
// rbd_checker
// Port-level checks of the run-length byte decoder, bound to the top level.
// ----------------------------------------------------------------------------
module rbd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_in_byte,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_out_lanes,
   input logic [2:0]  rsp_lane_count,
   input logic        rsp_last_of_input,
   input logic        rsp_stream_done,
   input logic [31:0] rsp_total_length,
   input logic        rsp_truncated
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_lanes)
                                 && $stable(rsp_total_length))
      else $error("stalled beat changed");

   a_lane_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_lane_count <= 3'd4)
      else $error("lane count above four");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_done |-> rsp_last_of_input)
      else $error("stream closed mid item");

   a_trunc_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_truncated |-> rsp_stream_done)
      else $error("truncated flag off the closing beat");

   a_empty_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_lane_count == 3'd0 |-> rsp_out_lanes == 32'd0
                                             && rsp_stream_done)
      else $error("empty beat carries data or does not close");

endmodule

bind rle_byte_decoder rbd_checker u_rbd_checker (.*);

### verif/rle_decode_check_pkg.sv
// ----------------------------------------------------------------------------
// rle_decode_check_pkg
// Expected-beat tracking for the run-length byte decoder: a bit-exact decoder
// of its own that turns each accepted byte into the beats it should cause, and
// an in-order comparison of the beats that come out.
// ----------------------------------------------------------------------------
package rle_decode_check_pkg;

   import rbd_pkg::*;

   // lanes per beat as the block clamps them
   localparam int unsigned BEAT_LANES = (OUT_LANES < 1) ? 1 : (OUT_LANES > 4) ? 4 : OUT_LANES;
   localparam int unsigned LOUD_MISMATCHES = 10;

   typedef enum logic [1:0] {
      AWAIT_HEADER    = 2'd0,
      AWAIT_RUN_VALUE = 2'd1,
      IN_LITERALS     = 2'd2
   } parse_phase_t;

   typedef struct packed {
      logic [31:0] lanes;
      logic [2:0]  count;
      logic        last_of_input;
      logic        stream_done;
      logic [31:0] total;
      logic        truncated;
   } decoded_beat_t;

   class decode_scoreboard;
      parse_phase_t  phase;
      logic [6:0]    owed;
      logic [31:0]   running;
      decoded_beat_t awaited[$];
      int unsigned   mismatches;

      function new();
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         phase   = AWAIT_HEADER;
         owed    = '0;
         running = '0;
      endfunction

      function int unsigned outstanding();
         return awaited.size();
      endfunction

      static function logic [31:0] add_sat(logic [31:0] a, int unsigned b);
         logic [32:0] s;
         s = {1'b0, a} + 33'(b);
         return s[32] ? 32'hFFFF_FFFF : s[31:0];
      endfunction

      // One accepted byte: work out its beats and queue them.
      function void note_byte(logic [7:0] value, logic closing);
         decoded_beat_t made [MAX_BEATS];
         int unsigned   n;
         int unsigned   left;
         int unsigned   take;
         logic [31:0]   splat;
         n = 0;
         case (phase)
            AWAIT_RUN_VALUE: begin
               left  = owed;
               splat = {4{value}};
               while (left > 0 && n < MAX_BEATS) begin
                  take = (left < BEAT_LANES) ? left : BEAT_LANES;
                  running = add_sat(running, take);
                  made[n] = '0;
                  made[n].lanes = splat & 32'((64'd1 << (8 * take)) - 64'd1);
                  made[n].count = 3'(take);
                  made[n].total = running;
                  n++;
                  left -= take;
               end
               // bytes past the beat limit still count towards the length
               if (left > 0) begin
                  running = add_sat(running, left);
                  made[n - 1].total = running;
               end
               phase = AWAIT_HEADER;
               owed  = '0;
            end
            IN_LITERALS: begin
               running = add_sat(running, 1);
               made[0] = '0;
               made[0].lanes = {24'd0, value};
               made[0].count = 3'd1;
               made[0].total = running;
               n = 1;
               if (owed != 0) owed--;
               if (owed == 0) phase = AWAIT_HEADER;
            end
            default: begin
               if ((value & RUN_FLAG) != 0) begin
                  phase = AWAIT_RUN_VALUE;
                  owed  = 7'(value & COUNT_MASK);
               end else if ((value & COUNT_MASK) != 0) begin
                  phase = IN_LITERALS;
                  owed  = 7'(value & COUNT_MASK);
               end
            end
         endcase
         if (closing && n == 0) begin
            made[0] = '0;
            made[0].total = running;
            n = 1;
         end
         if (n > 0) made[n - 1].last_of_input = 1'b1;
         if (closing) begin
            made[n - 1].stream_done = 1'b1;
            made[n - 1].truncated   = (phase != AWAIT_HEADER);
            restart();
         end
         for (int i = 0; i < n; i++) awaited.push_back(made[i]);
      endfunction

      function void complain(string field, logic [31:0] want, logic [31:0] got);
         mismatches++;
         if (mismatches <= LOUD_MISMATCHES)
            $display("mismatch on %s: expected %h, got %h", field, want, got);
      endfunction

      // One accepted beat against the oldest expectation.
      function void check_beat(decoded_beat_t seen);
         decoded_beat_t want;
         if (awaited.size() == 0) begin
            mismatches++;
            if (mismatches <= LOUD_MISMATCHES)
               $display("beat with nothing awaited: lanes %h count %0d total %0d",
                        seen.lanes, seen.count, seen.total);
            return;
         end
         want = awaited.pop_front();
         if (seen.lanes != want.lanes) complain("out_lanes", want.lanes, seen.lanes);
         if (seen.count != want.count) complain("lane_count", 32'(want.count), 32'(seen.count));
         if (seen.last_of_input != want.last_of_input)
            complain("last_of_input", 32'(want.last_of_input), 32'(seen.last_of_input));
         if (seen.stream_done != want.stream_done)
            complain("stream_done", 32'(want.stream_done), 32'(seen.stream_done));
         if (seen.total != want.total) complain("total_length", want.total, seen.total);
         if (seen.truncated != want.truncated)
            complain("truncated", 32'(want.truncated), 32'(seen.truncated));
      endfunction
   endclass

endpackage

### verif/rle_byte_decoder_test.sv
// ----------------------------------------------------------------------------
// rle_byte_decoder_test
// Drives compressed byte streams into the run-length decoder and checks every
// decoded beat, field by field and in order, against beats worked out from the
// accepted bytes. A short directed opening covers the corner cases, then random
// streams follow: mostly well-formed, some cut short, some pure noise.
// ----------------------------------------------------------------------------
module rle_byte_decoder_test;

   import rbd_pkg::*;
   import rle_decode_check_pkg::*;

   localparam int unsigned RANDOM_ITEMS    = 370;
   localparam int unsigned HOLD_OFF_CYCLES = 150;
   localparam int unsigned TAIL_CYCLES     = 16;
   localparam int unsigned CYCLE_LIMIT     = 400_000;
   localparam int unsigned OPENING_COUNT   = 22;

   // Opening items, {last, byte}. Each group is one corner case.
   localparam logic [8:0] OPENING_ITEMS [OPENING_COUNT] = '{
      9'h000,            // empty literal header, produces nothing
      9'h001, 9'h0FF,    // one literal, all ones
      9'h080, 9'h055,    // empty run still eats its value byte
      9'h085, 9'h0A5,    // run of five: a full beat and a single lane
      9'h0FF, 9'h000,    // longest run, 127 zeros, 32 beats
      9'h002, 9'h000, 9'h1FF,  // literals, stream closed cleanly on data
      9'h100,            // stream of one empty header: bare closing beat
      9'h183,            // closed on a run header: truncated
      9'h003, 9'h011, 9'h122,  // closed one literal early: truncated
      9'h080, 9'h177,    // closed on the value of an empty run
      9'h084, 9'h13C,    // exact four-lane run carries the close
      9'h17F             // closed on a long literal header
   };

   typedef enum logic [1:0] {
      DRAIN_FREE,        // never stalls
      DRAIN_SPARSE,      // stalls now and then
      DRAIN_ALTERNATE,   // stalls when the cycle count is odd
      DRAIN_HEAVY        // mostly stalled
   } drain_mode_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_out_lanes;
   logic [2:0]  rsp_lane_count;
   logic        rsp_last_of_input;
   logic        rsp_stream_done;
   logic [31:0] rsp_total_length;
   logic        rsp_truncated;

   decode_scoreboard sb = new();

   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;
   int unsigned burst_left = 0;
   bit          steady_feed = 1'b0;      // sender offers back to back, no gaps
   bit          hold_off_wanted = 1'b0;  // asks the result side for a long stall

   rle_byte_decoder dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Watchdog: a hung handshake or lost beat ends the run here.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb: failure");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Result side: stall pattern changes mode after each random span. A long
   // hold-off, when asked for, is counted here so the sender keeps going.
   // ---------------------------------------------------------------------
   initial begin : result_side
      drain_mode_t mode;
      int unsigned span;
      mode = DRAIN_FREE;
      span = 0;
      forever begin
         @(posedge clock);
         if (hold_off_wanted) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES - 1) @(posedge clock);
            hold_off_wanted = 1'b0;
         end else begin
            if (span == 0) begin
               mode = drain_mode_t'($urandom_range(0, 3));
               span = $urandom_range(16, 160);
            end
            span--;
            case (mode)
               DRAIN_FREE:      rsp_stall <= 1'b0;
               DRAIN_SPARSE:    rsp_stall <= ($urandom_range(0, 3) == 0);
               DRAIN_ALTERNATE: rsp_stall <= cycle_count[0];
               default:         rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // Beats are taken at the edge where valid is high and stall low; values
   // read here are those from before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_beat(decoded_beat_t'({rsp_out_lanes, rsp_lane_count, rsp_last_of_input,
                                         rsp_stream_done, rsp_total_length, rsp_truncated}));
   end

   // ---------------------------------------------------------------------
   // Sender. Items go out in bursts of random length with random gaps; a
   // call always returns at the edge that took the item, so the next call
   // either drives the following item at that same edge or drops valid.
   // ---------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] value, input logic closing);
      int unsigned gap;
      if (!steady_feed && burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      req_valid     <= 1'b1;
      req_in_byte   <= value;
      req_last_byte <= closing;
      do @(posedge clock); while (req_stall);
      sb.note_byte(value, closing);
      items_sent++;
      if (burst_left != 0) burst_left--;
   endtask

   // Drop valid and wait until no beat is awaited.
   task automatic drain_all();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
      burst_left = 0;
   endtask

   // Packet lengths: mostly short, a few near the top of the range.
   function automatic int unsigned pick_count();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return $urandom_range(0, 8);
      if (roll < 92) return $urandom_range(9, 40);
      return $urandom_range(41, 127);
   endfunction

   // Whole packet; closing marks its final byte as the end of the stream.
   task automatic send_packet(input bit is_run, input int unsigned count, input bit closing);
      if (is_run) begin
         send_byte(RUN_FLAG | 8'(count), 1'b0);
         send_byte(8'($urandom_range(0, 255)), closing);
      end else begin
         send_byte(8'(count) & COUNT_MASK, closing && count == 0);
         for (int i = 0; i < count; i++) send_byte(8'($urandom), closing && i == count - 1);
      end
   endtask

   task automatic send_whole_stream();
      int unsigned packets;
      packets = $urandom_range(1, 5);
      for (int i = 0; i < packets; i++)
         send_packet($urandom_range(0, 1), pick_count(), i == packets - 1);
   endtask

   // A few good packets, then the stream ends part-way into the next one.
   task automatic send_broken_stream();
      int unsigned whole;
      int unsigned count;
      int unsigned cut_at;
      whole = $urandom_range(0, 3);
      repeat (whole) send_packet($urandom_range(0, 1), pick_count(), 1'b0);
      if ($urandom_range(0, 1) == 1) begin
         // run header with no value byte
         send_byte(RUN_FLAG | 8'($urandom_range(0, 12)), 1'b1);
      end else begin
         count  = $urandom_range(1, 13);
         cut_at = $urandom_range(0, count - 1);
         send_byte(8'(count), cut_at == 0);
         for (int i = 1; i <= cut_at; i++) send_byte(8'($urandom), i == cut_at);
      end
   endtask

   // Random bytes with stray end marks; always closes so the next stream
   // starts clean.
   task automatic send_noise();
      int unsigned len;
      len = $urandom_range(1, 10);
      for (int i = 0; i < len; i++)
         send_byte(8'($urandom), i == len - 1 || $urandom_range(0, 7) == 0);
   endtask

   initial begin : stimulus
      int unsigned roll;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (OPENING_ITEMS[i]) send_byte(OPENING_ITEMS[i][7:0], OPENING_ITEMS[i][8]);

      // sender pause: nothing goes in until every beat is out
      drain_all();

      // long result-side stall while literals keep coming, back to back,
      // so the command queue fills and the input stalls
      hold_off_wanted = 1'b1;
      steady_feed     = 1'b1;
      send_packet(1'b0, 40, 1'b1);
      send_packet(1'b1, 127, 1'b1);
      steady_feed     = 1'b0;

      while (items_sent < OPENING_COUNT + RANDOM_ITEMS) begin
         roll = $urandom_range(0, 99);
         if (roll < 75)
            send_whole_stream();
         else if (roll < 90)
            send_broken_stream();
         else
            send_noise();
      end

      drain_all();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

### filelist.f
sv/rbd_pkg.sv
sv/rbd_front.sv
sv/rbd_queue.sv
sv/rbd_back.sv
sv/rle_byte_decoder.sv
sv/rbd_checker.sv
verif/rle_decode_check_pkg.sv
verif/rle_byte_decoder_test.sv
